### hdl/pkm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkm_pkg
// Shared widths, register indexes, reset values and types of the level meter.
// ----------------------------------------------------------------------------
package pkm_pkg;

   localparam int CHAN_W    = 3;
   localparam int LEVEL_W   = 16;
   localparam int COEF_W    = 16;
   localparam int CNT_W     = 10;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 16;
   localparam int ZONE_W    = 2;

   localparam logic [CSR_IDX_W-1:0] REG_DECAY_FACTOR    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RMS_COEFFICIENT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SILENCE_FLOOR   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_THRESHOLD  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_TICKS      = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_TICKS      = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HOT_LEVEL       = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_CAUTION_LEVEL   = 4'd7;

   localparam logic [COEF_W-1:0]  RST_DECAY_FACTOR    = 16'd60000;
   localparam logic [COEF_W-1:0]  RST_RMS_COEFFICIENT = 16'd52428;
   localparam logic [LEVEL_W-1:0] RST_SILENCE_FLOOR   = 16'd33;
   localparam logic [LEVEL_W-1:0] RST_CLIP_THRESHOLD  = 16'd32768;
   localparam logic [CNT_W-1:0]   RST_HOLD_TICKS      = 10'd45;
   localparam logic [CNT_W-1:0]   RST_CLIP_TICKS      = 10'd60;
   localparam logic [LEVEL_W-1:0] RST_HOT_LEVEL       = 16'd16423;
   localparam logic [LEVEL_W-1:0] RST_CAUTION_LEVEL   = 16'd4125;

   localparam logic [ZONE_W-1:0] ZONE_SAFE    = 2'd0;
   localparam logic [ZONE_W-1:0] ZONE_CAUTION = 2'd1;
   localparam logic [ZONE_W-1:0] ZONE_HOT     = 2'd2;
   localparam logic [ZONE_W-1:0] ZONE_CLIP    = 2'd3;

   typedef struct packed {
      logic [COEF_W-1:0]  decay_factor;
      logic [COEF_W-1:0]  rms_coefficient;
      logic [LEVEL_W-1:0] silence_floor;
      logic [LEVEL_W-1:0] clip_threshold;
      logic [CNT_W-1:0]   hold_ticks;
      logic [CNT_W-1:0]   clip_ticks;
      logic [LEVEL_W-1:0] hot_level;
      logic [LEVEL_W-1:0] caution_level;
   } cfg_type;

endpackage

### hdl/pkm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkm_if
// Valid/ready channels of the level meter: tick request, result, register write.
// ----------------------------------------------------------------------------
interface pkm_req_if import pkm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   chan;
   logic [LEVEL_W-1:0]  peak_level;
   logic [LEVEL_W-1:0]  rms_level;

   modport source (output valid, output chan, output peak_level, output rms_level,
                   input ready);
   modport sink   (input valid, input chan, input peak_level, input rms_level,
                   output ready);
endinterface

interface pkm_rsp_if import pkm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   out_chan;
   logic [LEVEL_W-1:0]  shown_peak;
   logic [LEVEL_W-1:0]  shown_rms;
   logic [LEVEL_W-1:0]  held_peak;
   logic                clip_active;
   logic [ZONE_W-1:0]   peak_zone;
   logic [ZONE_W-1:0]   rms_zone;

   modport source (output valid, output out_chan, output shown_peak, output shown_rms,
                   output held_peak, output clip_active, output peak_zone,
                   output rms_zone, input ready);
   modport sink   (input valid, input out_chan, input shown_peak, input shown_rms,
                   input held_peak, input clip_active, input peak_zone,
                   input rms_zone, output ready);
endinterface

interface pkm_csr_if import pkm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DAT_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/peak_rms_meter_ballistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_rms_meter_ballistics
// Per-channel peak/RMS meter ballistics with peak hold, clip hold and zones.
// ----------------------------------------------------------------------------
// Takes one tick item per clock while the result side does not stall and
// returns one result item per tick from its result register. An accepted
// item sits in an input register; one pass of logic (a 16x16 decay multiply
// and a 17x16 smoothing multiply beside compares) reads that channel's state,
// writes the new state and loads the result register in the same edge, so
// the next tick of the same channel already sees the update. Per-channel
// state lives in flip-flops and is cleared by reset. Register writes are
// always accepted; write them only while the meter is idle.
// ----------------------------------------------------------------------------
module peak_rms_meter_ballistics
   import pkm_pkg::*;
#(
   parameter int NUM_CHANNELS = 8
) (
   input  logic       clock,
   input  logic       reset,
   pkm_req_if.sink    req_bus,
   pkm_rsp_if.source  rsp_bus,
   pkm_csr_if.sink    csr_bus
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int EXT_W = (IDX_W > CHAN_W) ? IDX_W : CHAN_W;

   // configuration
   cfg_type cfg_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decay_factor    <= RST_DECAY_FACTOR;
         cfg_ff.rms_coefficient <= RST_RMS_COEFFICIENT;
         cfg_ff.silence_floor   <= RST_SILENCE_FLOOR;
         cfg_ff.clip_threshold  <= RST_CLIP_THRESHOLD;
         cfg_ff.hold_ticks      <= RST_HOLD_TICKS;
         cfg_ff.clip_ticks      <= RST_CLIP_TICKS;
         cfg_ff.hot_level       <= RST_HOT_LEVEL;
         cfg_ff.caution_level   <= RST_CAUTION_LEVEL;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_DECAY_FACTOR:    cfg_ff.decay_factor    <= csr_bus.data;
            REG_RMS_COEFFICIENT: cfg_ff.rms_coefficient <= csr_bus.data;
            REG_SILENCE_FLOOR:   cfg_ff.silence_floor   <= csr_bus.data;
            REG_CLIP_THRESHOLD:  cfg_ff.clip_threshold  <= csr_bus.data;
            REG_HOLD_TICKS:      cfg_ff.hold_ticks      <= csr_bus.data[CNT_W-1:0];
            REG_CLIP_TICKS:      cfg_ff.clip_ticks      <= csr_bus.data[CNT_W-1:0];
            REG_HOT_LEVEL:       cfg_ff.hot_level       <= csr_bus.data;
            REG_CAUTION_LEVEL:   cfg_ff.caution_level   <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   // input register
   logic               in_valid_ff;
   logic [CHAN_W-1:0]  chan_ff;
   logic [LEVEL_W-1:0] peak_ff;
   logic [LEVEL_W-1:0] rms_ff;

   logic rsp_valid_ff;
   logic advance;

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         chan_ff <= req_bus.chan;
         peak_ff <= req_bus.peak_level;
         rms_ff  <= req_bus.rms_level;
      end
   end

   // channel state
   logic [LEVEL_W-1:0] smooth_peak_ff [NUM_CHANNELS];
   logic [LEVEL_W-1:0] smooth_rms_ff  [NUM_CHANNELS];
   logic [LEVEL_W-1:0] hold_value_ff  [NUM_CHANNELS];
   logic [CNT_W-1:0]   hold_count_ff  [NUM_CHANNELS];
   logic [CNT_W-1:0]   clip_count_ff  [NUM_CHANNELS];

   logic [EXT_W-1:0]   chan_ext;
   logic [IDX_W-1:0]   idx;
   logic               chan_ok;

   assign chan_ext = EXT_W'(chan_ff);
   assign idx      = chan_ext[IDX_W-1:0];
   assign chan_ok  = (32'(chan_ff) < NUM_CHANNELS);

   logic [LEVEL_W-1:0] sp_old, sr_old, hv_old;
   logic [CNT_W-1:0]   hc_old, cc_old;

   assign sp_old = smooth_peak_ff[idx];
   assign sr_old = smooth_rms_ff[idx];
   assign hv_old = hold_value_ff[idx];
   assign hc_old = hold_count_ff[idx];
   assign cc_old = clip_count_ff[idx];

   // peak ballistics
   logic [LEVEL_W+COEF_W-1:0] decay_prod;
   logic [LEVEL_W-1:0]        decayed;
   logic [LEVEL_W-1:0]        smooth_peak_in;

   assign decay_prod = (LEVEL_W+COEF_W)'(sp_old) * (LEVEL_W+COEF_W)'(cfg_ff.decay_factor);
   assign decayed    = decay_prod[LEVEL_W+COEF_W-1:COEF_W];

   always_comb begin
      if (peak_ff > sp_old) begin
         smooth_peak_in = peak_ff;
      end else if (decayed < cfg_ff.silence_floor) begin
         smooth_peak_in = '0;
      end else begin
         smooth_peak_in = decayed;
      end
   end

   // rms smoothing: rms + (old - rms) * coef, all over 2^16
   logic signed [LEVEL_W:0]          rms_diff;
   logic signed [LEVEL_W+COEF_W+1:0] rms_prod;
   logic signed [LEVEL_W+COEF_W+1:0] rms_sum;
   logic [LEVEL_W-1:0]               smooth_rms_in;

   assign rms_diff = $signed({1'b0, sr_old}) - $signed({1'b0, rms_ff});
   assign rms_prod = (LEVEL_W+COEF_W+2)'(rms_diff)
                   * (LEVEL_W+COEF_W+2)'($signed({1'b0, cfg_ff.rms_coefficient}));
   assign rms_sum  = $signed({2'b00, rms_ff, {COEF_W{1'b0}}}) + rms_prod;
   assign smooth_rms_in = rms_sum[LEVEL_W+COEF_W-1:COEF_W];

   // peak hold and clip hold
   logic [LEVEL_W-1:0] hold_value_in;
   logic [CNT_W-1:0]   hold_count_in;
   logic [CNT_W-1:0]   clip_count_in;

   always_comb begin
      hold_value_in = hv_old;
      hold_count_in = hc_old;
      if (peak_ff > hv_old) begin
         hold_value_in = peak_ff;
         hold_count_in = cfg_ff.hold_ticks;
      end else if (hc_old != '0) begin
         hold_count_in = hc_old - CNT_W'(1);
         if (hc_old == CNT_W'(1)) begin
            hold_value_in = '0;
         end
      end
   end

   always_comb begin
      if (peak_ff >= cfg_ff.clip_threshold) begin
         clip_count_in = cfg_ff.clip_ticks;
      end else if (cc_old != '0) begin
         clip_count_in = cc_old - CNT_W'(1);
      end else begin
         clip_count_in = cc_old;
      end
   end

   function automatic logic [ZONE_W-1:0] zone_of(input logic [LEVEL_W-1:0] level,
                                                 input cfg_type cfg);
      logic [ZONE_W-1:0] zone;
      if (level >= cfg.hot_level) begin
         zone = ZONE_HOT;
      end else if (level >= cfg.caution_level) begin
         zone = ZONE_CAUTION;
      end else begin
         zone = ZONE_SAFE;
      end
      return zone;
   endfunction

   logic clip_in;
   assign clip_in = (clip_count_in != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            smooth_peak_ff[i] <= '0;
            smooth_rms_ff[i]  <= '0;
            hold_value_ff[i]  <= '0;
            hold_count_ff[i]  <= '0;
            clip_count_ff[i]  <= '0;
         end
      end else if (advance && chan_ok) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (IDX_W'(i) == idx) begin
               smooth_peak_ff[i] <= smooth_peak_in;
               smooth_rms_ff[i]  <= smooth_rms_in;
               hold_value_ff[i]  <= hold_value_in;
               hold_count_ff[i]  <= hold_count_in;
               clip_count_ff[i]  <= clip_count_in;
            end
         end
      end
   end

   // result register
   logic [CHAN_W-1:0]  out_chan_ff;
   logic [LEVEL_W-1:0] shown_peak_ff, shown_rms_ff, held_peak_ff;
   logic               clip_active_ff;
   logic [ZONE_W-1:0]  peak_zone_ff, rms_zone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_chan_ff <= chan_ff;
         if (chan_ok) begin
            shown_peak_ff  <= smooth_peak_in;
            shown_rms_ff   <= smooth_rms_in;
            held_peak_ff   <= hold_value_in;
            clip_active_ff <= clip_in;
            peak_zone_ff   <= clip_in ? ZONE_CLIP : zone_of(smooth_peak_in, cfg_ff);
            rms_zone_ff    <= zone_of(smooth_rms_in, cfg_ff);
         end else begin
            shown_peak_ff  <= '0;
            shown_rms_ff   <= '0;
            held_peak_ff   <= '0;
            clip_active_ff <= 1'b0;
            peak_zone_ff   <= ZONE_SAFE;
            rms_zone_ff    <= ZONE_SAFE;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_chan    = out_chan_ff;
   assign rsp_bus.shown_peak  = shown_peak_ff;
   assign rsp_bus.shown_rms   = shown_rms_ff;
   assign rsp_bus.held_peak   = held_peak_ff;
   assign rsp_bus.clip_active = clip_active_ff;
   assign rsp_bus.peak_zone   = peak_zone_ff;
   assign rsp_bus.rms_zone    = rms_zone_ff;

endmodule
